FILE: src/sirs_pkg.sv
// shared types and constants for the signed integer to radix symbols core
// no dependencies
`default_nettype none

package sirs_pkg;

   localparam int MAX_BASE   = 16;
   localparam int VALUE_W    = 32;
   localparam int LEN_W      = 5;
   localparam int SYM_W      = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int DIGIT_W    = $clog2(MAX_BASE);
   localparam int MAX_DIGITS = VALUE_W;
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int BYTE_W     = 8;
   localparam int DIV_STEPS  = VALUE_W / BYTE_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int SYMS_PER_WORD = CSR_DATA_W / SYM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic               load;
      logic               check;
      logic [DIGIT_W-1:0] check_idx;
      logic               divide;
      logic               div_last;
      logic               emit_fault;
      logic               emit_sign;
      logic               emit_digit;
   } sirs_cmd_type;

   typedef struct packed {
      logic alpha_bad;
      logic quot_zero;
      logic stack_full;
      logic neg;
      logic last_digit;
   } sirs_sts_type;

endpackage

`default_nettype wire

FILE: src/sirs_dp.sv
// datapath: configuration registers, alphabet check, byte-wide divider,
// digit stack and registered result outputs; uses sirs_pkg
`default_nettype none

module sirs_dp
   import sirs_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic signed [VALUE_W-1:0]    req_value,
   input  wire sirs_cmd_type                 cmd,
   output sirs_sts_type                      sts,
   output logic                              rsp_valid,
   output logic [SYM_W-1:0]                  rsp_symbol,
   output logic                              rsp_is_last,
   output logic                              rsp_base_invalid
);

   logic [LEN_W-1:0]                         len_ff;
   logic [2*SYMS_PER_WORD-1:0][SYM_W-1:0]    syms_ff;
   logic [VALUE_W-1:0]                       work_ff, work_in;
   logic [DIGIT_W-1:0]                       rem_ff;
   logic [COUNT_W-1:0]                       count_ff;
   logic [MAX_DIGITS-1:0][DIGIT_W-1:0]       stack_ff;
   logic                                     bad_ff, bad_in;
   logic                                     neg_ff;
   logic                                     valid_ff;
   logic [SYM_W-1:0]                         symbol_ff;
   logic                                     last_ff;
   logic                                     inv_ff;

   logic [SYM_W-1:0]   sym_i;
   logic               active_i;
   logic               bad_char;
   logic               dup;
   logic               len_bad;
   logic [DIGIT_W:0]   trial;
   logic [DIGIT_W-1:0] rem_in;
   logic [BYTE_W-1:0]  qbyte;

   // alphabet check: symbol forbidden or repeated later; length range
   always_comb begin
      sym_i    = syms_ff[cmd.check_idx];
      active_i = {1'b0, cmd.check_idx} < len_ff;
      bad_char = (sym_i == CHAR_NUL) || (sym_i == CHAR_PLUS) || (sym_i == CHAR_MINUS) ||
                 (sym_i == CHAR_SPACE) || ((sym_i >= CHAR_TAB) && (sym_i <= CHAR_CR));
      dup = 1'b0;
      for (int j = 0; j < 2*SYMS_PER_WORD; j++) begin
         if ((LEN_W'(j) > {1'b0, cmd.check_idx}) && (LEN_W'(j) < len_ff) &&
             (syms_ff[j] == sym_i)) begin
            dup = 1'b1;
         end
      end
      bad_in  = bad_ff | (active_i & (bad_char | dup));
      len_bad = (len_ff < LEN_W'(2)) || (len_ff > LEN_W'(MAX_BASE));
   end

   // one byte of restoring division per cycle
   always_comb begin
      rem_in = rem_ff;
      qbyte  = '0;
      trial  = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         trial = {rem_in, work_ff[VALUE_W-1-k]};
         if (trial >= len_ff) begin
            qbyte[BYTE_W-1-k] = 1'b1;
            rem_in = DIGIT_W'(trial - len_ff);
         end else begin
            rem_in = trial[DIGIT_W-1:0];
         end
      end
      work_in = {work_ff[VALUE_W-BYTE_W-1:0], qbyte};
   end

   assign sts.alpha_bad  = bad_ff | len_bad;
   assign sts.quot_zero  = (work_in == '0);
   assign sts.stack_full = (count_ff == COUNT_W'(MAX_DIGITS - 1));
   assign sts.neg        = neg_ff;
   assign sts.last_digit = (count_ff == COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         syms_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_LENGTH:  len_ff <= csr_wdata[LEN_W-1:0];
            CSR_SYMBOLS_LOW:  syms_ff[SYMS_PER_WORD-1:0] <= csr_wdata;
            CSR_SYMBOLS_HIGH: syms_ff[2*SYMS_PER_WORD-1:SYMS_PER_WORD] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         priority if (cmd.load) begin
            work_ff  <= req_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(req_value))
                                             : $unsigned(req_value);
            neg_ff   <= req_value[VALUE_W-1];
            rem_ff   <= '0;
            count_ff <= '0;
            bad_ff   <= 1'b0;
         end else if (cmd.check) begin
            bad_ff <= bad_in;
         end else if (cmd.divide) begin
            work_ff <= work_in;
            if (cmd.div_last) begin
               rem_ff   <= '0;
               stack_ff <= {stack_ff[MAX_DIGITS-2:0], rem_in};
               count_ff <= count_ff + COUNT_W'(1);
            end else begin
               rem_ff <= rem_in;
            end
         end else if (cmd.emit_digit) begin
            stack_ff <= {DIGIT_W'(0), stack_ff[MAX_DIGITS-1:1]};
            count_ff <= count_ff - COUNT_W'(1);
         end else begin
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_fault | cmd.emit_sign | cmd.emit_digit;
      end
      priority if (cmd.emit_fault) begin
         symbol_ff <= '0;
         last_ff   <= 1'b1;
         inv_ff    <= 1'b1;
      end else if (cmd.emit_sign) begin
         symbol_ff <= CHAR_MINUS;
         last_ff   <= 1'b0;
         inv_ff    <= 1'b0;
      end else begin
         symbol_ff <= syms_ff[stack_ff[0]];
         last_ff   <= (count_ff == COUNT_W'(1));
         inv_ff    <= 1'b0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbol       = symbol_ff;
   assign rsp_is_last      = last_ff;
   assign rsp_base_invalid = inv_ff;

   a_fault_form: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && inv_ff) |-> (last_ff && (symbol_ff == '0)))
      else $error("fault result malformed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_DIGITS))
      else $error("digit count overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (count_ff != '0))
      else $error("pop from empty digit stack");

endmodule

`default_nettype wire

FILE: src/sirs_ctrl.sv
// controller state machine: sequences alphabet check, division and output
// uses sirs_pkg command and status types
`default_nettype none

module sirs_ctrl
   import sirs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output sirs_cmd_type      cmd,
   input  wire sirs_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [DIGIT_W-1:0]  idx_ff, idx_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      cmd            = '0;
      cmd.check_idx  = idx_ff;
      cmd.div_last   = (step_ff == STEP_W'(DIV_STEPS - 1));
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            idx_in    = idx_ff + DIGIT_W'(1);
            if (idx_ff == DIGIT_W'(MAX_BASE - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            step_in = '0;
            if (sts.alpha_bad) begin
               cmd.emit_fault = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            step_in    = step_ff + STEP_W'(1);
            if (cmd.div_last && (sts.quot_zero || sts.stack_full)) begin
               state_in = sts.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            if (sts.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy out of step with state");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.check, cmd.divide, cmd.emit_fault, cmd.emit_sign,
                cmd.emit_digit}))
      else $error("more than one datapath command");

   a_fault_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_fault |=> (state_ff == ST_IDLE))
      else $error("fault did not end the request");

endmodule

`default_nettype wire

FILE: src/signed_integer_to_radix_symbols_core.sv
// top level: signed integer to radix symbols converter
// instantiates sirs_ctrl and sirs_dp, uses sirs_pkg
//
//   channel   ports                                         direction
//   request   start, busy, req_value                         in (busy out)
//   result    rsp_valid, rsp_symbol, rsp_is_last,
//             rsp_base_invalid                                out
//   config    csr_we, csr_index, csr_wdata                   in
//
// a request runs the alphabet check over every symbol slot and a decision, then
// divides the magnitude byte by byte in the byte-wide divider for each digit, then sends
// the symbols out, sign first; an invalid alphabet ends after the decision with one fault result
// the divider, one byte of quotient per cycle, sets the digit rate
// synchronous reset clears control and configuration; results cannot be stalled
`default_nettype none

module signed_integer_to_radix_symbols_core
   import sirs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   output logic [SYM_W-1:0]               rsp_symbol,
   output logic                           rsp_is_last,
   output logic                           rsp_base_invalid,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata
);

   sirs_cmd_type cmd;
   sirs_sts_type sts;

   sirs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   sirs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_value        (req_value),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_is_last      (rsp_is_last),
      .rsp_base_invalid (rsp_base_invalid)
   );

endmodule

`default_nettype wire

FILE: test/tb_signed_integer_to_radix_symbols_core.sv
`timescale 1ns / 1ps
// testbench for signed_integer_to_radix_symbols_core: directed and random requests
// checked symbol by symbol against a behavioural predictor; needs sirs_pkg and the core

module tb_signed_integer_to_radix_symbols_core;
   import sirs_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int RANDOM_ITEMS   = 296;
   localparam int SETTLE_CYCLES  = 200;
   localparam int ALPHA_W        = MAX_BASE * SYM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             is_last;
      logic             base_invalid;
   } radix_symbol_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic [SYM_W-1:0]          rsp_symbol;
   logic                      rsp_is_last;
   logic                      rsp_base_invalid;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // configuration as the core should hold it
   logic [LEN_W-1:0]   base_len = '0;
   logic [ALPHA_W-1:0] alphabet_cfg = '0;

   radix_symbol_type pending_symbols[$];
   int errors = 0;
   int requests_sent = 0;
   int symbols_checked = 0;
   int settings_applied = 0;

   signed_integer_to_radix_symbols_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_is_last      (rsp_is_last),
      .rsp_base_invalid (rsp_base_invalid),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic bit symbol_forbidden(input logic [SYM_W-1:0] c);
      return c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE ||
             (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic bit alphabet_ok();
      int i;
      int j;
      if (base_len < 2 || base_len > MAX_BASE) return 1'b0;
      for (i = 0; i < base_len; i++) begin
         if (symbol_forbidden(alphabet_cfg[i*SYM_W +: SYM_W])) return 1'b0;
         for (j = i + 1; j < base_len; j++)
            if (alphabet_cfg[j*SYM_W +: SYM_W] == alphabet_cfg[i*SYM_W +: SYM_W]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_symbols(input logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      logic [DIGIT_W-1:0] digs[MAX_DIGITS];
      int                 nd;
      int                 k;
      if (!alphabet_ok()) begin
         pending_symbols.push_back('{CHAR_NUL, 1'b1, 1'b1});
         return;
      end
      mag   = raw[VALUE_W-1] ? -raw : raw;
      radix = VALUE_W'(base_len);
      nd    = 0;
      do begin
         digs[nd] = DIGIT_W'(mag % radix);
         mag      = mag / radix;
         nd++;
      end while (mag != 0 && nd < MAX_DIGITS);
      if (raw[VALUE_W-1]) pending_symbols.push_back('{CHAR_MINUS, 1'b0, 1'b0});
      for (k = nd - 1; k >= 0; k--)
         pending_symbols.push_back('{alphabet_cfg[int'(digs[k])*SYM_W +: SYM_W], k == 0, 1'b0});
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_symbols.size() == 0) begin
            errors++;
            $display("%0t: unexpected symbol %02h last %0b invalid %0b", $time,
                     rsp_symbol, rsp_is_last, rsp_base_invalid);
         end else begin
            automatic radix_symbol_type exp_sym = pending_symbols.pop_front();
            symbols_checked++;
            if (rsp_symbol !== exp_sym.symbol) begin
               errors++;
               $display("%0t: symbol expected %02h got %02h", $time, exp_sym.symbol, rsp_symbol);
            end
            if (rsp_is_last !== exp_sym.is_last) begin
               errors++;
               $display("%0t: is_last expected %0b got %0b", $time, exp_sym.is_last, rsp_is_last);
            end
            if (rsp_base_invalid !== exp_sym.base_invalid) begin
               errors++;
               $display("%0t: base_invalid expected %0b got %0b", $time, exp_sym.base_invalid,
                        rsp_base_invalid);
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_BASE_LENGTH:  base_len = data[LEN_W-1:0];
         CSR_SYMBOLS_LOW:  alphabet_cfg[CSR_DATA_W-1:0] = data;
         CSR_SYMBOLS_HIGH: alphabet_cfg[ALPHA_W-1:CSR_DATA_W] = data;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits of the length word carry noise, the core keeps only the low bits
   task automatic set_alphabet(input int len, input logic [ALPHA_W-1:0] alpha);
      logic [CSR_DATA_W-1:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = len[LEN_W-1:0];
      csr_write(CSR_BASE_LENGTH, len_word);
      csr_write(CSR_SYMBOLS_LOW, alpha[CSR_DATA_W-1:0]);
      csr_write(CSR_SYMBOLS_HIGH, alpha[ALPHA_W-1:CSR_DATA_W]);
      settings_applied++;
   endtask

   task automatic send_value(input logic [VALUE_W-1:0] v, input int gap);
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      predict_symbols(v);
      requests_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_symbols.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 8);
      if (r < 95) return $urandom_range(9, 60);
      return $urandom_range(61, 220);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      longint unsigned  p;
      int               r;
      int               steps;
      logic [VALUE_W-1:0] v;
      r = (base_len >= 2 && base_len <= MAX_BASE) ? int'(base_len) : 10;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3: v = $urandom_range(0, 300);
         4: v = $urandom >> $urandom_range(0, 31);
         5: begin
            case ($urandom_range(0, 4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = '1;
               3: v = '0;
               default: v = 32'h8000_0001;
            endcase
         end
         6, 7: begin
            // around a power of the radix, where the digit count changes
            p = 1;
            steps = $urandom_range(1, 31);
            while (steps > 0 && p * r <= 64'h8000_0000) begin
               p = p * r;
               steps--;
            end
            v = p[VALUE_W-1:0] - 1 + $urandom_range(0, 2);
         end
         default: v = $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic configure_random_alphabet(output bit valid);
      int                 len;
      int                 i;
      int                 j;
      int                 kind;
      bit                 clash;
      logic [SYM_W-1:0]   c;
      logic [ALPHA_W-1:0] alpha;
      alpha = {$urandom, $urandom, $urandom, $urandom};
      kind  = $urandom_range(0, 19);
      case ($urandom_range(0, 5))
         0: len = 2;
         1: len = MAX_BASE;
         default: len = $urandom_range(2, MAX_BASE);
      endcase
      for (i = 0; i < len; i++) begin
         do begin
            c = SYM_W'($urandom_range(0, 255));
            clash = symbol_forbidden(c);
            for (j = 0; j < i; j++)
               if (alpha[j*SYM_W +: SYM_W] == c) clash = 1'b1;
         end while (clash);
         alpha[i*SYM_W +: SYM_W] = c;
      end
      case (kind)
         0: len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(MAX_BASE + 1, 31);
         1: begin
            case ($urandom_range(0, 4))
               0: c = CHAR_NUL;
               1: c = CHAR_PLUS;
               2: c = CHAR_MINUS;
               3: c = CHAR_SPACE;
               default: c = CHAR_TAB + SYM_W'($urandom_range(0, CHAR_CR - CHAR_TAB));
            endcase
            alpha[$urandom_range(0, len - 1)*SYM_W +: SYM_W] = c;
         end
         2: begin
            i = $urandom_range(0, len - 2);
            j = $urandom_range(i + 1, len - 1);
            alpha[j*SYM_W +: SYM_W] = alpha[i*SYM_W +: SYM_W];
         end
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0) csr_write(CSR_UNUSED, {$urandom, $urandom});
      set_alphabet(len, alpha);
      valid = alphabet_ok();
   endtask

   // alphabet left at reset has length zero
   task automatic test_reset_alphabet();
      send_value(32'd0, 0);
      drain();
   endtask

   task automatic test_decimal_extremes();
      set_alphabet(10, {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130});
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      send_value(32'd0, 0);
      send_value(32'd7, pick_gap());
      send_value(-32'sd1, 0);
      send_value(32'd10, pick_gap());
      send_value(32'h7FFF_FFFF, 0);
      send_value(32'h8000_0000, 0);
      send_value(32'h8000_0001, pick_gap());
      drain();
   endtask

   task automatic test_binary_longest();
      set_alphabet(2, {{14{8'h00}}, 8'h01, 8'hFF});
      send_value(32'h8000_0000, 0);
      send_value(32'hFFFF_FFFF, 0);
      send_value(32'h7FFF_FFFF, pick_gap());
      drain();
   endtask

   task automatic test_full_alphabet();
      set_alphabet(MAX_BASE, {64'h4342_41FF_FE80_7F2F, 64'h2E2C_2A21_1F0E_0801});
      send_value(32'h8000_0000, 0);
      send_value(32'hFEDC_BA98, 0);
      drain();
   endtask

   task automatic check_alphabet_case(input int len, input logic [ALPHA_W-1:0] alpha);
      set_alphabet(len, alpha);
      send_value($urandom, 0);
      drain();
   endtask

   task automatic test_invalid_alphabets();
      logic [ALPHA_W-1:0] dec;
      logic [ALPHA_W-1:0] hex;
      logic [ALPHA_W-1:0] a;
      dec = {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
      hex = {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};
      check_alphabet_case(1, dec);
      check_alphabet_case(MAX_BASE + 1, hex);
      check_alphabet_case(31, hex);
      a = dec; a[0*SYM_W +: SYM_W] = CHAR_PLUS;
      check_alphabet_case(10, a);
      a = dec; a[9*SYM_W +: SYM_W] = CHAR_MINUS;
      check_alphabet_case(10, a);
      a = hex; a[15*SYM_W +: SYM_W] = CHAR_SPACE;
      check_alphabet_case(MAX_BASE, a);
      a = dec; a[3*SYM_W +: SYM_W] = CHAR_TAB;
      check_alphabet_case(10, a);
      a = dec; a[5*SYM_W +: SYM_W] = CHAR_CR;
      check_alphabet_case(10, a);
      a = dec; a[1*SYM_W +: SYM_W] = CHAR_NUL;
      check_alphabet_case(10, a);
      a = hex; a[15*SYM_W +: SYM_W] = a[0*SYM_W +: SYM_W];
      check_alphabet_case(MAX_BASE, a);
      // bad symbols past the length are ignored
      a = {{12{CHAR_MINUS}}, 32'h6463_6261};
      set_alphabet(4, a);
      send_value(32'h8000_0000 | $urandom, 0);
      drain();
   endtask

   task automatic test_random_conversions();
      int sent;
      int phase_len;
      bit no_idle;
      bit valid;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         configure_random_alphabet(valid);
         phase_len = valid ? $urandom_range(8, 30) : $urandom_range(2, 5);
         no_idle   = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            send_value(pick_value(), no_idle ? 0 : pick_gap());
            sent++;
         end
         drain();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_alphabet();
      test_decimal_extremes();
      test_binary_longest();
      test_full_alphabet();
      test_invalid_alphabets();
      test_random_conversions();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_symbols.size() != 0) begin
         errors++;
         $display("%0t: %0d symbols never arrived", $time, pending_symbols.size());
      end
      $display("tb: %0d requests over %0d alphabet settings, %0d symbols compared",
               requests_sent, settings_applied, symbols_checked);
      $display("tb: covered radix 2 to 16, invalid alphabets and the most negative value");
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("%0t: timeout", $time);
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
src/sirs_pkg.sv
src/sirs_dp.sv
src/sirs_ctrl.sv
src/signed_integer_to_radix_symbols_core.sv
test/tb_signed_integer_to_radix_symbols_core.sv
